>>> hdl/prcx_pkg.sv
// Shared types and decode constants for the PC-relative reference scanner.
`default_nettype none

package prcx_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned WORD_W = 32;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ADR    = 2'd1,
		KIND_ADRP   = 2'd2,
		KIND_BRANCH = 2'd3
	} ref_kind_t;

	localparam logic [WORD_W-1:0] ADR_MASK    = 32'h9F00_0000;
	localparam logic [WORD_W-1:0] ADR_MATCH   = 32'h1000_0000;
	localparam logic [WORD_W-1:0] ADRP_MATCH  = 32'h9000_0000;
	localparam logic [WORD_W-1:0] B_MASK      = 32'h7C00_0000;
	localparam logic [WORD_W-1:0] B_MATCH     = 32'h1400_0000;
	localparam logic [WORD_W-1:0] ADD_MASK    = 32'hFF00_0000;
	localparam logic [WORD_W-1:0] ADD_MATCH   = 32'h9100_0000;

	localparam logic [1:0] ADD_SHIFT_NONE = 2'd0;
	localparam logic [1:0] ADD_SHIFT_12   = 2'd1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		ref_kind_t         kind;
	} dec_res_t;

	typedef struct packed {
		logic is_hit;
		logic first_hit;
	} hit_res_t;

endpackage

`default_nettype wire

>>> hdl/prcx_decode.sv
// Combinational decode of ADR, ADRP plus ADD, and B or BL target addresses.
`default_nettype none

module prcx_decode (
	input  wire logic [prcx_pkg::WORD_W-1:0] instr_word,
	input  wire logic [prcx_pkg::WORD_W-1:0] next_word,
	input  wire logic [prcx_pkg::ADDR_W-1:0] word_address,
	output prcx_pkg::dec_res_t               res
);
	import prcx_pkg::*;

	logic [ADDR_W-1:0] imm21_sext;
	logic [ADDR_W-1:0] br_sext;
	logic [ADDR_W-1:0] adr_addr;
	logic [ADDR_W-1:0] page;
	logic [ADDR_W-1:0] add_imm;
	logic [ADDR_W-1:0] adrp_addr;
	logic [ADDR_W-1:0] br_addr;
	logic              adr_ok;
	logic              adrp_ok;
	logic              br_ok;
	logic [1:0]        add_shift;
	logic              shift_ok;

	// Immediate is immhi (bits 23..5) above immlo (bits 30..29).
	assign imm21_sext = {{(ADDR_W-21){instr_word[23]}}, instr_word[23:5], instr_word[30:29]};
	assign br_sext    = {{(ADDR_W-28){instr_word[25]}}, instr_word[25:0], 2'b00};

	assign adr_addr = word_address + imm21_sext;
	assign page     = {word_address[ADDR_W-1:12], 12'h000} + {imm21_sext[ADDR_W-13:0], 12'h000};
	assign add_shift = next_word[23:22];
	assign shift_ok  = (add_shift == ADD_SHIFT_NONE) || (add_shift == ADD_SHIFT_12);
	assign add_imm   = (add_shift == ADD_SHIFT_12) ?
		{{(ADDR_W-24){1'b0}}, next_word[21:10], 12'h000} :
		{{(ADDR_W-12){1'b0}}, next_word[21:10]};
	assign adrp_addr = page + add_imm;
	assign br_addr   = word_address + br_sext;

	// A form whose sum is zero counts as no reference and the next form is tried.
	assign adr_ok  = ((instr_word & ADR_MASK) == ADR_MATCH) && (adr_addr != '0);
	assign adrp_ok = ((instr_word & ADR_MASK) == ADRP_MATCH)
		&& ((next_word & ADD_MASK) == ADD_MATCH) && shift_ok
		&& (instr_word[4:0] == next_word[9:5]) && (adrp_addr != '0);
	assign br_ok   = ((instr_word & B_MASK) == B_MATCH) && (br_addr != '0);

	always_comb begin
		if (adr_ok) begin
			res.addr = adr_addr;
			res.kind = KIND_ADR;
		end else if (adrp_ok) begin
			res.addr = adrp_addr;
			res.kind = KIND_ADRP;
		end else if (br_ok) begin
			res.addr = br_addr;
			res.kind = KIND_BRANCH;
		end else begin
			res.addr = '0;
			res.kind = KIND_NONE;
		end
	end

endmodule

`default_nettype wire

>>> hdl/prcx_match.sv
// Target compare and first-hit tracking across a scan.
`default_nettype none

module prcx_match (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic                        last_word,
	input  wire logic [prcx_pkg::ADDR_W-1:0] target_address,
	input  wire logic [prcx_pkg::ADDR_W-1:0] ref_address,
	output prcx_pkg::hit_res_t               hit
);
	import prcx_pkg::*;

	logic hit_seen_q;

	assign hit.is_hit    = (target_address != '0) && (ref_address == target_address);
	assign hit.first_hit = hit.is_hit && !hit_seen_q;

	// The last word of a scan still reports against the old state, then clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_seen_q <= 1'b0;
		end else if (advance) begin
			if (last_word) begin
				hit_seen_q <= 1'b0;
			end else if (hit.is_hit) begin
				hit_seen_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/pc_relative_xref_scanner_unit.sv
// Top level of the PC-relative reference scanner: input and result registers.
`default_nettype none

// Scans a stream of AArch64 instruction words and reports, for each word, the
// address it refers to through ADR, ADRP followed by a matching ADD, or B/BL,
// together with a hit flag against target_address and a first-hit flag that
// resets after the word marked with tlast. Every request gives one result. The
// block takes one request per cycle while the result side is not stalled; each
// request passes through the input register and then the result register, where
// decode, the address adders and the target compare sit between the two, and the
// result register lets a new request enter while a result waits to be taken.
// target_address must be written only while no request is in flight.
module pc_relative_xref_scanner_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         target_wr_en,
	input  wire logic [63:0]  target_wr_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// instr_word [31:0], next_word [63:32], word_address [127:64]
	input  wire logic [127:0] s_tdata,
	// last_word
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// ref_address [63:0]
	output logic [63:0]       m_tdata,
	// ref_kind [1:0], is_hit [2], first_hit [3]
	output logic [3:0]        m_tuser
);
	import prcx_pkg::*;

	logic [ADDR_W-1:0] target_q;

	logic              v_s1;
	logic [WORD_W-1:0] instr_s1;
	logic [WORD_W-1:0] next_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic              last_s1;

	logic              v_s2;
	logic [ADDR_W-1:0] addr_s2;
	ref_kind_t         kind_s2;
	logic              hit_s2;
	logic              first_s2;

	logic              advance;
	dec_res_t          dec;
	hit_res_t          hit;

	assign advance  = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_wr_en) begin
			target_q <= target_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= s_tdata[31:0];
			next_s1  <= s_tdata[63:32];
			pc_s1    <= s_tdata[127:64];
			last_s1  <= s_tlast;
		end
	end

	prcx_decode u_decode (
		.instr_word   (instr_s1),
		.next_word    (next_s1),
		.word_address (pc_s1),
		.res          (dec)
	);

	prcx_match u_match (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.last_word      (last_s1),
		.target_address (target_q),
		.ref_address    (dec.addr),
		.hit            (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2  <= dec.addr;
			kind_s2  <= dec.kind;
			hit_s2   <= hit.is_hit;
			first_s2 <= hit.first_hit;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = addr_s2;
	assign m_tuser  = {first_s2, hit_s2, kind_s2};

endmodule

`default_nettype wire

>>> hdl/prcx_checker.sv
// Port-level checks for the scanner and the bind that attaches them.
`default_nettype none

module prcx_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         target_wr_en,
	input wire logic [63:0]  target_wr_data,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [63:0]  m_tdata,
	input wire logic [3:0]   m_tuser
);
	import prcx_pkg::*;

	logic [63:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_wr_en) begin
			target_q <= target_wr_data;
		end
	end

	// A reported hit must carry the nonzero target as its address.
	a_hit_matches_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (target_q != '0) && (m_tdata[63:0] == target_q))
		else $error("hit reported on an address other than the target");

	// A first hit is always a hit on a decoded reference.
	a_first_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tuser[2] && (m_tuser[1:0] != KIND_NONE)))
		else $error("first hit without a hit");

	// No reference means a zero address and no hit.
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == KIND_NONE)) |-> ((m_tdata[63:0] == '0) && !m_tuser[2]))
		else $error("no reference reported with a nonzero address or a hit");

	// A stalled result holds.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind pc_relative_xref_scanner_unit prcx_checker u_prcx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.target_wr_en   (target_wr_en),
	.target_wr_data (target_wr_data),
	.m_tvalid       (m_tvalid),
	.m_tready       (m_tready),
	.m_tdata        (m_tdata),
	.m_tuser        (m_tuser)
);

`default_nettype wire

>>> tb/pc_relative_xref_scanner_unit_tb.sv
// Self-checking testbench for the PC-relative reference scanner top level.
`timescale 1ns / 1ps

module pc_relative_xref_scanner_unit_tb;

	import prcx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned DIR_SPLIT   = 3;
	localparam logic [63:0] DIR_TARGET  = 64'h0000_0000_0040_2468;

	// Shift encodings of the ADD immediate that the block must reject.
	localparam logic [1:0] ADD_SHIFT_RSV2 = 2'd2;
	localparam logic [1:0] ADD_SHIFT_RSV3 = 2'd3;

	typedef struct packed {
		logic [63:0] addr;
		ref_kind_t   kind;
		logic        is_hit;
		logic        first_hit;
	} xref_t;

	typedef struct {
		logic [31:0] word;
		logic [31:0] next;
		logic [63:0] pc;
		logic        last;
		logic        typed;
		xref_t       want;
	} scan_row_t;

	localparam xref_t NO_REF = '{64'h0, KIND_NONE, 1'b0, 1'b0};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         target_wr_en = 1'b0;
	logic [63:0]  target_wr_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [3:0]   m_tuser;

	// Testbench copy of the block's configuration and first-hit state.
	logic [63:0]  target_q = '0;
	logic         hit_seen_q = 1'b0;

	xref_t        expected_refs[$];
	scan_row_t    stim_rows[$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	bit           src_idle_on = 1'b1;
	bit           sink_idle_on = 1'b1;
	bit           hold_req = 1'b0;

	pc_relative_xref_scanner_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_wr_en   (target_wr_en),
		.target_wr_data (target_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] sext21(input logic [20:0] v);
		return {{43{v[20]}}, v};
	endfunction

	function automatic logic [63:0] sext_branch(input logic [25:0] imm26);
		return {{36{imm26[25]}}, imm26, 2'b00};
	endfunction

	function automatic logic [31:0] enc_adr(input logic [4:0] rd, input logic [20:0] v);
		return ADR_MATCH | {1'b0, v[1:0], 29'b0} | {8'b0, v[20:2], 5'b0} | {27'b0, rd};
	endfunction

	function automatic logic [31:0] enc_adrp(input logic [4:0] rd, input logic [20:0] v);
		return enc_adr(rd, v) | ADRP_MATCH;
	endfunction

	function automatic logic [31:0] enc_add(input logic [4:0] rd, input logic [4:0] rn,
			input logic [11:0] imm12, input logic [1:0] sh);
		return ADD_MATCH | {8'b0, sh, imm12, rn, rd};
	endfunction

	function automatic logic [31:0] enc_b(input logic link, input logic [25:0] imm26);
		return B_MATCH | {link, 5'b0, imm26};
	endfunction

	// Decodes one word the way the block should and advances the first-hit state.
	function automatic xref_t scan_predict(input logic [31:0] w, input logic [31:0] n,
			input logic [63:0] pc, input logic last);
		xref_t       r;
		logic [63:0] imm;
		logic [63:0] sum;
		logic [63:0] page;
		logic [63:0] add_imm;
		r = NO_REF;
		imm = sext21({w[23:5], w[30:29]});
		if ((w & ADR_MASK) == ADR_MATCH) begin
			sum = pc + imm;
			if (sum != 64'h0) begin
				r.addr = sum;
				r.kind = KIND_ADR;
			end
		end
		if (r.kind == KIND_NONE && (w & ADR_MASK) == ADRP_MATCH &&
				(n & ADD_MASK) == ADD_MATCH && w[4:0] == n[9:5] &&
				(n[23:22] == ADD_SHIFT_NONE || n[23:22] == ADD_SHIFT_12)) begin
			page = (pc & ~64'hFFF) + (imm << 12);
			add_imm = (n[23:22] == ADD_SHIFT_12) ? {40'b0, n[21:10], 12'b0} : {52'b0, n[21:10]};
			sum = page + add_imm;
			if (sum != 64'h0) begin
				r.addr = sum;
				r.kind = KIND_ADRP;
			end
		end
		if (r.kind == KIND_NONE && (w & B_MASK) == B_MATCH) begin
			sum = pc + sext_branch(w[25:0]);
			if (sum != 64'h0) begin
				r.addr = sum;
				r.kind = KIND_BRANCH;
			end
		end
		r.is_hit = (target_q != 64'h0) && (r.addr == target_q);
		r.first_hit = r.is_hit && !hit_seen_q;
		if (r.is_hit)
			hit_seen_q = 1'b1;
		if (last)
			hit_seen_q = 1'b0;
		return r;
	endfunction

	task automatic add_row(input logic [31:0] w, input logic [31:0] n, input logic [63:0] pc,
			input logic last, input logic typed, input xref_t want);
		scan_row_t row;
		row.word = w;
		row.next = n;
		row.pc = pc;
		row.last = last;
		row.typed = typed;
		row.want = want;
		stim_rows.push_back(row);
	endtask

	// Offers one request and waits until the block takes it.
	task automatic offer_word(input logic [31:0] w, input logic [31:0] n, input logic [63:0] pc,
			input logic last, input logic typed, input xref_t want);
		xref_t pred;
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tdata <= {pc, n, w};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = scan_predict(w, n, pc, last);
		expected_refs.push_back(typed ? want : pred);
	endtask

	task automatic park_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (expected_refs.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_target(input logic [63:0] value);
		@(negedge clk);
		target_wr_en <= 1'b1;
		target_wr_data <= value;
		target_q = value;
		@(negedge clk);
		target_wr_en <= 1'b0;
	endtask

	// Mostly well-formed references, many of them aimed at the current target.
	task automatic pick_item(output logic [31:0] w, output logic [31:0] n,
			output logic [63:0] pc, output logic last);
		int unsigned sel;
		logic        aim;
		logic [20:0] v;
		logic [25:0] imm26;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [11:0] imm12;
		logic [1:0]  sh;
		logic [31:0] rnd;
		sel = $urandom_range(0, 99);
		aim = ($urandom_range(0, 9) < 4);
		v = 21'($urandom);
		imm26 = 26'($urandom);
		rd = 5'($urandom);
		rnd = $urandom;
		n = $urandom;
		if ($urandom_range(0, 3) == 0)
			pc = {$urandom, $urandom};
		else
			pc = {32'h0, $urandom};
		if (sel < 30) begin
			w = enc_adr(rd, v);
			if (aim)
				pc = target_q - sext21(v);
		end else if (sel < 60) begin
			w = enc_adrp(rd, v);
			imm12 = 12'($urandom);
			sh = ($urandom_range(0, 9) == 0) ?
				2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
			rn = ($urandom_range(0, 7) == 0) ? 5'($urandom) : rd;
			if (aim) begin
				n = enc_add(5'($urandom), rd, target_q[11:0], ADD_SHIFT_NONE);
				pc = (((target_q & ~64'hFFF) - (sext21(v) << 12)) & ~64'hFFF) |
					{52'b0, rnd[11:0]};
			end else if ($urandom_range(0, 9) != 0) begin
				n = enc_add(5'($urandom), rn, imm12, sh);
			end
		end else if (sel < 85) begin
			w = enc_b(1'($urandom), imm26);
			if (aim)
				pc = target_q - sext_branch(imm26);
		end else begin
			w = $urandom;
		end
		last = ($urandom_range(0, 7) == 0);
	endtask

	task automatic run_random(input int count, input int hold_at, input int pause_at);
		logic [31:0] w;
		logic [31:0] n;
		logic [63:0] pc;
		logic        last;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at) begin
				park_sender();
				wait_results_drained();
			end
			pick_item(w, n, pc, last);
			offer_word(w, n, pc, last, 1'b0, NO_REF);
		end
		park_sender();
		wait_results_drained();
	endtask

	// Receiver: random stalls, plus one long hold-off when requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		xref_t exp_ref;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_refs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: tdata=%h tuser=%h", m_tdata, m_tuser);
			end else begin
				exp_ref = expected_refs.pop_front();
				if (m_tdata[63:0] !== exp_ref.addr ||
						m_tuser[1:0] !== exp_ref.kind || m_tuser[2] !== exp_ref.is_hit ||
						m_tuser[3] !== exp_ref.first_hit) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: want %h/%0d/%b/%b got %h/%0d/%b/%b",
							exp_ref.addr, exp_ref.kind, exp_ref.is_hit, exp_ref.first_hit,
							m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		// The first rows run with the reset target of zero, so no hit is possible.
		add_row(32'h0, 32'h0, 64'h0, 1'b0, 1'b1, NO_REF);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, NO_REF);
		add_row(enc_adr(5'd0, 21'd0), 32'h0, 64'h1000, 1'b0, 1'b1,
			'{64'h1000, KIND_ADR, 1'b0, 1'b0});
		// The remaining rows run against DIR_TARGET and are checked by prediction.
		add_row(enc_adr(5'd0, 21'd4), 32'h0, DIR_TARGET - 64'd4, 1'b0, 1'b0, NO_REF);
		add_row(enc_b(1'b1, 26'd2), 32'h0, DIR_TARGET - 64'd8, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd3, 21'd0), enc_add(5'd7, 5'd3, 12'h468, ADD_SHIFT_NONE),
			DIR_TARGET, 1'b1, 1'b0, NO_REF);
		add_row(enc_adr(5'd0, 21'd4), 32'h0, DIR_TARGET - 64'd4, 1'b0, 1'b0, NO_REF);
		add_row(enc_adr(5'd31, 21'h0FFFFF), 32'h0, 64'h1000_0000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adr(5'd0, 21'h100000), 32'h0, 64'h1000_0000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adr(5'd1, 21'h1FFFFC), 32'h0, 64'h4, 1'b0, 1'b0, NO_REF);
		add_row(enc_adr(5'd2, 21'd8), 32'h0, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd5, 21'h1FFFFF), enc_add(5'd5, 5'd5, 12'hFFF, ADD_SHIFT_12),
			64'h8000_1234, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd9, 21'h0FFFFF), enc_add(5'd1, 5'd9, 12'h0, ADD_SHIFT_NONE),
			64'h5000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd4, 21'd0), enc_add(5'd4, 5'd4, 12'h005, ADD_SHIFT_NONE),
			64'hABC, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd4, 21'd0), enc_add(5'd4, 5'd4, 12'h000, ADD_SHIFT_NONE),
			64'h10, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd3, 21'd1), enc_add(5'd3, 5'd3, 12'h001, ADD_SHIFT_RSV2),
			64'h2000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd3, 21'd1), enc_add(5'd3, 5'd3, 12'h001, ADD_SHIFT_RSV3),
			64'h2000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd3, 21'd1), enc_add(5'd3, 5'd4, 12'h001, ADD_SHIFT_NONE),
			64'h2000, 1'b0, 1'b0, NO_REF);
		add_row(enc_adrp(5'd3, 21'd1), 32'h1100_0063, 64'h2000, 1'b0, 1'b0, NO_REF);
		add_row(enc_b(1'b0, 26'h1FF_FFFF), 32'h0, 64'h1000, 1'b0, 1'b0, NO_REF);
		add_row(enc_b(1'b0, 26'h200_0000), 32'h0, 64'h1_0000_0000, 1'b0, 1'b0, NO_REF);
		add_row(enc_b(1'b0, 26'h3FF_FFFE), 32'h0, 64'h8, 1'b0, 1'b0, NO_REF);
		add_row(32'hD503_201F, 32'h0, 64'h4000, 1'b1, 1'b0, NO_REF);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stim_rows.size(); i++) begin
			if (i == DIR_SPLIT) begin
				park_sender();
				wait_results_drained();
				load_target(DIR_TARGET);
			end
			offer_word(stim_rows[i].word, stim_rows[i].next, stim_rows[i].pc,
				stim_rows[i].last, stim_rows[i].typed, stim_rows[i].want);
		end
		park_sender();
		wait_results_drained();

		load_target({32'h0, 8'h40, 24'($urandom)});
		run_random(90, 45, -1);
		load_target(64'hFFFF_FFFF_FFFF_FFFF);
		run_random(80, -1, 40);
		load_target(64'h0);
		run_random(60, -1, -1);
		load_target(64'h1);
		run_random(80, -1, -1);
		load_target({$urandom, $urandom});
		run_random(90, -1, -1);

		// Back-to-back traffic at full rate for the closing stretch.
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		load_target({32'h0, $urandom});
		run_random(100, -1, -1);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
